// ===== sv/itf_pkg.sv =====
package itf_pkg;

	// ascii codes used by the formatter
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_UPPER_A = 8'h41;
	localparam logic [7:0] CH_LOWER_A = 8'h61;

	// radix limits and the digit whose glyph is the hex prefix letter
	localparam logic [5:0] BASE_MIN = 6'd2;
	localparam logic [5:0] BASE_MAX = 6'd36;
	localparam logic [5:0] BASE_OCT = 6'd8;
	localparam logic [5:0] BASE_HEX = 6'd16;
	localparam logic [5:0] DIGIT_X  = 6'd33;
	localparam logic [5:0] DEC_DIGITS = 6'd10;

	typedef struct packed {
		logic [63:0] value;
		logic [5:0]  base;
		logic [6:0]  width;
		logic [6:0]  precision;
		logic        zero_pad;
		logic        signed_mode;
		logic        plus_sign;
		logic        space_sign;
		logic        left_justify;
		logic        alt_prefix;
		logic        lower_case;
		logic [6:0]  length_limit;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_char;
		logic       char_valid;
		logic       last;
		logic       bad_base;
	} out_item_t;

	// divider control and status
	typedef struct packed {
		logic start;
		logic load;
	} div_cmd_t;

	typedef struct packed {
		logic       done;
		logic [5:0] digit;
		logic       quot_zero;
	} div_stat_t;

	// digit value to its glyph in the selected letter case
	function automatic logic [7:0] digit_char(input logic [5:0] d, input logic lower);
		logic [7:0] c;
		if (d < DEC_DIGITS) begin
			c = CH_ZERO + {2'b00, d};
		end else begin
			c = (lower ? CH_LOWER_A : CH_UPPER_A) + {2'b00, d} - {2'b00, DEC_DIGITS};
		end
		return c;
	endfunction

endpackage

// ===== sv/itf_div.sv =====
module itf_div #(
	parameter int VALUE_BITS = 64
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  itf_pkg::div_cmd_t       cmd,
	input  logic [VALUE_BITS-1:0]   value,
	input  logic [5:0]              base,
	output itf_pkg::div_stat_t      stat
);

	localparam int DW    = ((VALUE_BITS + 7) / 8) * 8;
	localparam int STEPS = DW / 8;
	localparam int SW    = (STEPS > 1) ? $clog2(STEPS) : 1;
	localparam logic [SW-1:0] LAST_STEP = SW'(STEPS - 1);

	logic [DW-1:0] work_q;
	logic [5:0]    rem_q;
	logic [SW-1:0] step_q;
	logic          busy_q;
	logic          done_q;

	logic [DW-1:0] work_n;
	logic [5:0]    rem_n;
	logic [6:0]    trial;

	// eight restoring divide steps: dividend bits leave the top, quotient bits enter the bottom
	always_comb begin
		work_n = work_q;
		rem_n  = rem_q;
		trial  = '0;
		for (int i = 0; i < 8; i++) begin
			trial  = {rem_n, work_n[DW-1]};
			work_n = {work_n[DW-2:0], 1'b0};
			if (trial >= {1'b0, base}) begin
				trial     = trial - {1'b0, base};
				work_n[0] = 1'b1;
			end
			rem_n = trial[5:0];
		end
	end

	// sequencer control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (cmd.start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == LAST_STEP) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// working dividend and partial remainder
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			if (cmd.load) begin
				work_q <= DW'(value);
			end
			rem_q <= '0;
		end else if (busy_q) begin
			work_q <= work_n;
			rem_q  <= rem_n;
		end
	end

	assign stat.done      = done_q;
	assign stat.digit     = rem_q;
	assign stat.quot_zero = ~|work_q;

endmodule

// ===== sv/integer_to_text_formatter.sv =====
// flow: the item is accepted, its digits are produced one at a time by the single divider,
// S_PLAN and S_BOUND lay out the field, then one character per cycle while the output register can be loaded.
// throughput: one item at a time; the next item is taken once the final result of the
// previous one is loaded into the output register.
// reset: asynchronous, active low; clears the sequencer, divider control and output valid.
module integer_to_text_formatter #(
	parameter int MAX_CHARS  = 64,
	parameter int VALUE_BITS = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  itf_pkg::in_item_t    in_item,
	output logic                 out_valid,
	input  logic                 out_ready,
	output itf_pkg::out_item_t   out_item
);

	localparam int LIM_CAP = (MAX_CHARS < 127) ? MAX_CHARS : 127;
	localparam int NDW     = $clog2(VALUE_BITS + 1);

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_DIV   = 5'b00010,
		S_PLAN  = 5'b00100,
		S_BOUND = 5'b01000,
		S_EMIT  = 5'b10000
	} state_t;

	state_t state_q;

	// latched item settings
	logic [5:0] base_q;
	logic [6:0] width_q;
	logic [6:0] prec_q;
	logic       zp_q;
	logic       left_q;
	logic       lower_q;
	logic [6:0] lim_q;
	logic       has_sign_q;
	logic [7:0] sign_char_q;
	logic [1:0] pre_len_q;
	logic       empty_q;
	logic       bad_q;

	// digit stack, most significant digit ends on top
	logic [5:0]     digits_q [VALUE_BITS];
	logic [NDW-1:0] nd_q;

	// layout of the field
	logic [6:0] lead_q, mid_q, trail_q, zeros_q;
	logic [8:0] b1_q, b2_q, b3_q, b5_q, b6_q;
	logic [6:0] total_q;
	logic [6:0] idx_q;

	logic                  out_valid_q;
	itf_pkg::out_item_t    out_item_q;

	// accept side
	logic                  accept;
	logic                  bad_c;
	logic [VALUE_BITS-1:0] raw_c;
	logic                  neg_c;
	logic [VALUE_BITS-1:0] mag_c;
	logic [6:0]            lim_c;

	// divider link
	itf_pkg::div_cmd_t  div_cmd;
	itf_pkg::div_stat_t div_stat;
	logic               push;
	logic               pop;

	// planning
	logic [6:0] prec_eff_c;
	logic [7:0] need_c;
	logic [6:0] pad_c;
	logic [8:0] c1, c2, c3, c4, c5, c6, end_c;
	logic [6:0] total_c;

	// emission
	logic       can_load;
	logic [8:0] idx_ext;
	logic [7:0] char_c;

	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;
	assign can_load = !out_valid_q || out_ready;

	// input conditioning
	always_comb begin
		bad_c = (in_item.base < itf_pkg::BASE_MIN) || (in_item.base > itf_pkg::BASE_MAX);
		raw_c = in_item.value[VALUE_BITS-1:0];
		neg_c = in_item.signed_mode && raw_c[VALUE_BITS-1];
		mag_c = neg_c ? (VALUE_BITS'(0) - raw_c) : raw_c;
		lim_c = (in_item.length_limit > 7'(LIM_CAP)) ? 7'(LIM_CAP) : in_item.length_limit;
	end

	// divider commands
	assign push          = (state_q == S_DIV) && div_stat.done;
	assign div_cmd.start = (accept && !bad_c) || (push && !div_stat.quot_zero);
	assign div_cmd.load  = accept;

	itf_div #(
		.VALUE_BITS(VALUE_BITS)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (div_cmd),
		.value  (mag_c),
		.base   (base_q),
		.stat   (div_stat)
	);

	// pad and digit counts
	always_comb begin
		prec_eff_c = (prec_q > 7'(nd_q)) ? prec_q : 7'(nd_q);
		need_c     = 8'(has_sign_q) + 8'(pre_len_q) + 8'(prec_eff_c);
		pad_c      = ({1'b0, width_q} > need_c) ? 7'({1'b0, width_q} - need_c) : 7'd0;
	end

	// running boundaries of the field sections
	always_comb begin
		c1      = 9'(lead_q);
		c2      = c1 + 9'(has_sign_q);
		c3      = c2 + 9'(pre_len_q);
		c4      = c3 + 9'(mid_q);
		c5      = c4 + 9'(zeros_q);
		c6      = c5 + 9'(nd_q);
		end_c   = c6 + 9'(trail_q);
		total_c = (end_c > 9'(lim_q)) ? lim_q : 7'(end_c);
	end

	// character at the current position
	always_comb begin
		idx_ext = 9'(idx_q);
		pop     = 1'b0;
		if (idx_ext < b1_q) begin
			char_c = itf_pkg::CH_SPACE;
		end else if (idx_ext < b2_q) begin
			char_c = sign_char_q;
		end else if (idx_ext < b3_q) begin
			char_c = (idx_ext == b2_q) ? itf_pkg::CH_ZERO
			                           : itf_pkg::digit_char(itf_pkg::DIGIT_X, lower_q);
		end else if (idx_ext < b5_q) begin
			char_c = itf_pkg::CH_ZERO;
		end else if (idx_ext < b6_q) begin
			char_c = itf_pkg::digit_char(digits_q[0], lower_q);
			pop    = (state_q == S_EMIT) && can_load && !empty_q;
		end else begin
			char_c = itf_pkg::CH_SPACE;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= bad_c ? S_EMIT : S_DIV;
					end
				end
				S_DIV: begin
					if (push && div_stat.quot_zero) begin
						state_q <= S_PLAN;
					end
				end
				S_PLAN: begin
					state_q <= S_BOUND;
				end
				S_BOUND: begin
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (can_load) begin
						out_valid_q <= 1'b1;
						if (empty_q || (7'(idx_q + 1'b1) == total_q)) begin
							state_q <= S_IDLE;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// item settings, layout and output payload
	always_ff @(posedge clk) begin
		if (accept) begin
			base_q      <= in_item.base;
			width_q     <= in_item.width;
			prec_q      <= in_item.precision;
			zp_q        <= in_item.zero_pad && !in_item.left_justify;
			left_q      <= in_item.left_justify;
			lower_q     <= in_item.lower_case;
			lim_q       <= lim_c;
			has_sign_q  <= neg_c || in_item.plus_sign || in_item.space_sign;
			sign_char_q <= neg_c ? itf_pkg::CH_MINUS
			             : (in_item.plus_sign ? itf_pkg::CH_PLUS : itf_pkg::CH_SPACE);
			pre_len_q   <= !in_item.alt_prefix ? 2'd0
			             : (in_item.base == itf_pkg::BASE_HEX) ? 2'd2
			             : (in_item.base == itf_pkg::BASE_OCT) ? 2'd1 : 2'd0;
			empty_q     <= bad_c;
			bad_q       <= bad_c;
			nd_q        <= '0;
			idx_q       <= '0;
		end
		if (push) begin
			nd_q <= nd_q + 1'b1;
		end
		if (state_q == S_PLAN) begin
			lead_q  <= (!zp_q && !left_q) ? pad_c : 7'd0;
			mid_q   <= zp_q ? pad_c : 7'd0;
			trail_q <= left_q ? pad_c : 7'd0;
			zeros_q <= prec_eff_c - 7'(nd_q);
		end
		if (state_q == S_BOUND) begin
			b1_q    <= c1;
			b2_q    <= c2;
			b3_q    <= c3;
			b5_q    <= c5;
			b6_q    <= c6;
			total_q <= total_c;
			empty_q <= (total_c == 7'd0);
		end
		if ((state_q == S_EMIT) && can_load) begin
			if (empty_q) begin
				out_item_q.out_char   <= 8'd0;
				out_item_q.char_valid <= 1'b0;
				out_item_q.last       <= 1'b1;
				out_item_q.bad_base   <= bad_q;
			end else begin
				out_item_q.out_char   <= char_c;
				out_item_q.char_valid <= 1'b1;
				out_item_q.last       <= (7'(idx_q + 1'b1) == total_q);
				out_item_q.bad_base   <= 1'b0;
				idx_q                 <= idx_q + 1'b1;
			end
		end
	end

	// digit stack: push shifts up, pop shifts down
	always_ff @(posedge clk) begin
		if (push) begin
			digits_q[0] <= div_stat.digit;
			for (int i = 1; i < VALUE_BITS; i++) begin
				digits_q[i] <= digits_q[i-1];
			end
		end else if (pop) begin
			for (int i = 0; i < VALUE_BITS - 1; i++) begin
				digits_q[i] <= digits_q[i+1];
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

endmodule

// ===== tb/sv/tb.sv =====
// expected characters for each accepted request, checked in arrival order
class char_scoreboard;
	itf_pkg::out_item_t pending_chars[$];
	int errors;

	function new();
		errors = 0;
	endfunction

	// digit value to ascii in the requested letter case
	function logic [7:0] glyph(int unsigned d, bit lower);
		if (d < 10) begin
			return itf_pkg::CH_ZERO + 8'(d);
		end
		return (lower ? itf_pkg::CH_LOWER_A : itf_pkg::CH_UPPER_A) + 8'(d) - 8'd10;
	endfunction

	// format one request into the characters it should produce
	function void note_request(itf_pkg::in_item_t req);
		logic [63:0] mag;
		logic [63:0] radix;
		logic [7:0] sign_ch;
		logic [7:0] digits[$];
		logic [7:0] text[$];
		int fld;
		int prec;
		int lim;
		int n;
		bit zp;
		bit is_oct;
		bit is_hex;
		itf_pkg::out_item_t c;

		mag = req.value;
		radix = 64'(req.base);
		fld = int'(req.width);
		prec = int'(req.precision);
		lim = (req.length_limit > 7'd64) ? 64 : int'(req.length_limit);
		zp = req.zero_pad && !req.left_justify;
		is_oct = req.alt_prefix && (req.base == itf_pkg::BASE_OCT);
		is_hex = req.alt_prefix && (req.base == itf_pkg::BASE_HEX);

		// radix out of range gives a single error marker
		if (req.base < itf_pkg::BASE_MIN || req.base > itf_pkg::BASE_MAX) begin
			c = '{out_char: 8'h00, char_valid: 1'b0, last: 1'b1, bad_base: 1'b1};
			pending_chars.push_back(c);
			return;
		end

		// sign selection and its share of the field
		sign_ch = 8'h00;
		if (req.signed_mode && mag[63]) begin
			sign_ch = itf_pkg::CH_MINUS;
			mag = ~mag + 64'd1;
		end else if (req.plus_sign) begin
			sign_ch = itf_pkg::CH_PLUS;
		end else if (req.space_sign) begin
			sign_ch = itf_pkg::CH_SPACE;
		end
		if (sign_ch != 8'h00) fld--;
		if (is_hex) fld -= 2;
		if (is_oct) fld--;

		// digits, least significant first; zero still yields one digit
		do begin
			digits.push_back(glyph(int'(mag % radix), req.lower_case));
			mag = mag / radix;
		end while (mag != 64'd0);
		if (digits.size() > prec) prec = digits.size();
		fld -= prec;

		// assemble the full text, the limit is applied afterwards
		if (!zp && !req.left_justify) begin
			for (; fld > 0; fld--) text.push_back(itf_pkg::CH_SPACE);
		end
		if (sign_ch != 8'h00) text.push_back(sign_ch);
		if (is_oct || is_hex) text.push_back(itf_pkg::CH_ZERO);
		if (is_hex) text.push_back(glyph(itf_pkg::DIGIT_X, req.lower_case));
		if (!req.left_justify) begin
			for (; fld > 0; fld--) text.push_back(zp ? itf_pkg::CH_ZERO : itf_pkg::CH_SPACE);
		end
		for (int k = prec; k > digits.size(); k--) text.push_back(itf_pkg::CH_ZERO);
		for (int k = digits.size() - 1; k >= 0; k--) text.push_back(digits[k]);
		for (; fld > 0; fld--) text.push_back(itf_pkg::CH_SPACE);

		// truncate at the length limit, empty text gives an end marker
		n = (text.size() < lim) ? text.size() : lim;
		if (n == 0) begin
			c = '{out_char: 8'h00, char_valid: 1'b0, last: 1'b1, bad_base: 1'b0};
			pending_chars.push_back(c);
		end
		for (int k = 0; k < n; k++) begin
			c = '{out_char: text[k], char_valid: 1'b1, last: (k == n - 1), bad_base: 1'b0};
			pending_chars.push_back(c);
		end
	endfunction

	// compare one output transfer with the oldest expected character
	function void check_char(itf_pkg::out_item_t got);
		itf_pkg::out_item_t want;
		if (pending_chars.size() == 0) begin
			$error("unexpected transfer: out_char %h char_valid %b last %b bad_base %b",
				got.out_char, got.char_valid, got.last, got.bad_base);
			errors++;
			return;
		end
		want = pending_chars.pop_front();
		if (got.out_char !== want.out_char) begin
			$error("out_char: expected %h, got %h", want.out_char, got.out_char);
			errors++;
		end
		if (got.char_valid !== want.char_valid) begin
			$error("char_valid: expected %b, got %b", want.char_valid, got.char_valid);
			errors++;
		end
		if (got.last !== want.last) begin
			$error("last: expected %b, got %b", want.last, got.last);
			errors++;
		end
		if (got.bad_base !== want.bad_base) begin
			$error("bad_base: expected %b, got %b", want.bad_base, got.bad_base);
			errors++;
		end
	endfunction
endclass

module tb;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	itf_pkg::in_item_t in_item = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	itf_pkg::out_item_t out_item;

	char_scoreboard sb = new();
	int sent = 0;

	integer_to_text_formatter dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_item(in_item),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_item(out_item)
	);

	// clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// watchdog
	initial begin
		#30000000;
		$display("TEST FAILED");
		$finish;
	end

	// transfer monitor on both channels
	always @(posedge clk) begin
		if (in_valid && in_ready) sb.note_request(in_item);
		if (out_valid && out_ready) sb.check_char(out_item);
	end

	// idle length: mostly none or short, sometimes long
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// request with no flags and the full length limit
	function automatic itf_pkg::in_item_t plain(logic [63:0] v, logic [5:0] b);
		itf_pkg::in_item_t r;
		r = '0;
		r.value = v;
		r.base = b;
		r.length_limit = 7'd64;
		return r;
	endfunction

	// random request biased toward interesting values and radixes
	function automatic itf_pkg::in_item_t random_request();
		itf_pkg::in_item_t r;
		int pick;
		r = plain({$urandom, $urandom}, 6'd10);
		case ($urandom_range(0, 7))
			0: r.value = 64'($urandom_range(0, 40));
			1: r.value = 64'h8000_0000_0000_0000;
			2: r.value = {{56{1'b1}}, 8'($urandom)};
			3: r.value = 64'($urandom);
			default: r.value = {$urandom, $urandom};
		endcase
		case ($urandom_range(0, 9))
			0: r.base = 6'd2;
			1: r.base = itf_pkg::BASE_OCT;
			2, 3: r.base = itf_pkg::BASE_HEX;
			4: r.base = 6'd10;
			5: r.base = itf_pkg::BASE_MAX;
			6, 7: r.base = 6'($urandom_range(2, 36));
			8: begin
				pick = $urandom_range(0, 28);
				r.base = 6'((pick < 2) ? pick : pick + 35);
			end
			default: r.base = 6'($urandom_range(0, 63));
		endcase
		r.width = 7'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 64) : $urandom_range(0, 24));
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4: r.precision = 7'd0;
			5, 6, 7: r.precision = 7'($urandom_range(0, 24));
			default: r.precision = 7'($urandom_range(0, 64));
		endcase
		r.zero_pad = 1'($urandom_range(0, 1));
		r.signed_mode = 1'($urandom_range(0, 1));
		r.plus_sign = 1'($urandom_range(0, 1));
		r.space_sign = 1'($urandom_range(0, 1));
		r.left_justify = 1'($urandom_range(0, 1));
		r.alt_prefix = 1'($urandom_range(0, 1));
		r.lower_case = 1'($urandom_range(0, 1));
		if ($urandom_range(0, 9) < 3) r.length_limit = 7'($urandom_range(0, 64));
		return r;
	endfunction

	// offer one request and hold it until the transfer; valid stays up when back to back
	task automatic send_request(itf_pkg::in_item_t r);
		int gap;
		gap = ((sent / 16) % 3 == 2) ? 0 : pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_item <= r;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		sent++;
	endtask

	// receiver with random stalls and one long hold-off to back up the block
	initial begin
		int gap;
		int taken;
		bit held;
		taken = 0;
		held = 0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			gap = ((taken / 60) % 3 == 2) ? 0 : pick_gap();
			if (!held && taken >= 200) begin
				held = 1;
				gap = 400;
			end
			if (gap > 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			taken++;
		end
	end

	// reset, directed requests, random requests, drain
	initial begin
		itf_pkg::in_item_t r;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// zero, all ones in binary, most negative value, minus one in hex with the plus flag
		send_request(plain(64'd0, 6'd10));
		send_request(plain('1, 6'd2));
		r = plain(64'h8000_0000_0000_0000, 6'd10); r.signed_mode = 1'b1;
		send_request(r);
		r = plain('1, itf_pkg::BASE_HEX); r.signed_mode = 1'b1; r.plus_sign = 1'b1;
		send_request(r);

		// sign flags with space and zero padding, left justify cancels zero pad
		r = plain(64'd123, 6'd10); r.plus_sign = 1'b1; r.width = 7'd10;
		send_request(r);
		r = plain(64'd5, 6'd10); r.space_sign = 1'b1; r.zero_pad = 1'b1; r.width = 7'd8;
		send_request(r);
		r = plain(64'd42, 6'd10); r.left_justify = 1'b1; r.zero_pad = 1'b1;
		r.plus_sign = 1'b1; r.width = 7'd12;
		send_request(r);

		// alternate prefixes in hex, octal and a radix without one
		r = plain(64'hDEAD_BEEF, itf_pkg::BASE_HEX); r.alt_prefix = 1'b1; r.lower_case = 1'b1;
		send_request(r);
		r = plain(64'hBEEF, itf_pkg::BASE_HEX); r.alt_prefix = 1'b1; r.zero_pad = 1'b1;
		r.width = 7'd20;
		send_request(r);
		r = plain(64'o755, itf_pkg::BASE_OCT); r.alt_prefix = 1'b1; r.width = 7'd10;
		send_request(r);
		r = plain(64'd0, itf_pkg::BASE_OCT); r.alt_prefix = 1'b1;
		send_request(r);
		r = plain(64'd99, 6'd10); r.alt_prefix = 1'b1;
		send_request(r);

		// top radix in both cases
		r = plain('1, itf_pkg::BASE_MAX); r.lower_case = 1'b1;
		send_request(r);
		send_request(plain(64'h7FFF_FFFF_FFFF_FFFF, itf_pkg::BASE_MAX));

		// radix out of range
		send_request(plain(64'd7, 6'd0));
		send_request(plain(64'd7, 6'd1));
		send_request(plain(64'd7, 6'd37));
		r = plain('1, 6'd63); r.width = 7'd64; r.precision = 7'd64; r.zero_pad = 1'b1;
		r.signed_mode = 1'b1; r.plus_sign = 1'b1; r.space_sign = 1'b1;
		r.left_justify = 1'b1; r.alt_prefix = 1'b1; r.lower_case = 1'b1;
		send_request(r);

		// nothing emitted, short limit, padding cut off by the limit
		r = plain(64'd12345, 6'd10); r.length_limit = 7'd0;
		send_request(r);
		r = plain(64'd9876543210, 6'd10); r.length_limit = 7'd3;
		send_request(r);
		r = plain('1, 6'd10); r.signed_mode = 1'b1; r.width = 7'd64; r.precision = 7'd64;
		send_request(r);
		r = plain(64'd7, 6'd10); r.precision = 7'd64;
		send_request(r);
		r = plain(64'd0, itf_pkg::BASE_HEX); r.alt_prefix = 1'b1; r.left_justify = 1'b1;
		r.width = 7'd64;
		send_request(r);
		r = plain('1, 6'd2); r.precision = 7'd64; r.width = 7'd64; r.zero_pad = 1'b1;
		r.space_sign = 1'b1;
		send_request(r);

		// random requests
		for (int i = 0; i < 126; i++) send_request(random_request());

		// drain everything still expected, then allow a little slack
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending_chars.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (sb.errors == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end
endmodule
